[rtl/ppr_pkg.sv]
// Package for the pinhole primary ray generator.
// Widths, register codes and the shared pipeline word type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ppr_pkg;

  localparam int DIR_FRAC_BITS    = 14;
  localparam int SAMPLE_FRAC_BITS = 4;
  localparam int XF               = 16;

  localparam int SAMPLE_W = 16;
  localparam int SIZE_W   = 13;
  localparam int VIEW_W   = 16;
  localparam int VEC_W    = 18;
  localparam int POS_W    = 20;
  localparam int FOCUS_W  = 24;
  localparam int DIR_W    = 16;

  localparam int VIEW_REG_W = 3 * VIEW_W;
  localparam int VEC_REG_W  = 3 * VEC_W;
  localparam int POS_REG_W  = 3 * POS_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = POS_REG_W;

  // sample mapping divider
  localparam int DEN_W = SIZE_W + SAMPLE_FRAC_BITS;
  localparam int MAG_W = (SAMPLE_W + 1 > DEN_W) ? SAMPLE_W + 1 : DEN_W;
  localparam int NUM_W = MAG_W + XF + 1;
  localparam int MQ_W  = MAG_W + XF - SAMPLE_FRAC_BITS + 1;
  localparam int MAP_W = MQ_W + 1;

  // direction sum and normalization
  localparam int PROD_W  = VEC_W + MAP_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int NORM_W  = 64;
  localparam int NSH     = $clog2(NORM_W);
  localparam int NM_W    = 30;

  // length
  localparam int SQ_W     = 2 * NM_W;
  localparam int SS_W     = SQ_W + 2;
  localparam int RES_W    = SS_W + 1;
  localparam int LEN_W    = SS_W / 2;
  localparam int SQ_STEPS = LEN_W;

  // per-component quotient
  localparam int QN_W = NM_W + DIR_FRAC_BITS + 1;
  localparam int QQ_W = DIR_FRAC_BITS + 2;
  localparam int QR_W = LEN_W;

  localparam logic [DIR_W-1:0]   DIR_ONE   = DIR_W'(1 << DIR_FRAC_BITS);
  localparam logic [FOCUS_W-1:0] FOCUS_ONE = FOCUS_W'(1 << DIR_FRAC_BITS);

  localparam logic [SIZE_W-1:0] FILM_WIDTH_RST  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] FILM_HEIGHT_RST = SIZE_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILM_WIDTH      = 3'd0,
    CFG_FILM_HEIGHT     = 3'd1,
    CFG_VIEW_DIRECTION  = 3'd2,
    CFG_RIGHT_SCALED    = 3'd3,
    CFG_UP_SCALED       = 3'd4,
    CFG_FOCUS_DISTANCE  = 3'd5,
    CFG_CAMERA_POSITION = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0][NM_W-1:0] mag;
    logic [2:0]           neg;
    logic                 zero;
  } norm_t;

endpackage

`default_nettype wire

[rtl/ppr_ifs.sv]
// Valid/ready channel interfaces for samples and rays.
// Depends on ppr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ppr_sample_if import ppr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_x;
  logic [SAMPLE_W-1:0] sample_y;

  modport source (output valid, sample_x, sample_y, input ready);
  modport sink (input valid, sample_x, sample_y, output ready);
endinterface

interface ppr_ray_if import ppr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] origin_x;
  logic signed [POS_W-1:0] origin_y;
  logic signed [POS_W-1:0] origin_z;
  logic signed [DIR_W-1:0] dir_x;
  logic signed [DIR_W-1:0] dir_y;
  logic signed [DIR_W-1:0] dir_z;
  logic                    degenerate;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  degenerate, input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                degenerate, output ready);
endinterface

`default_nettype wire

[rtl/ppr_map.sv]
// Sample mapping: maps both film coordinates to -1..1 with a pipelined
// restoring divider, one quotient bit per stage. Depends on ppr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppr_map import ppr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [SAMPLE_W-1:0]      sample_x_i,
  input  logic [SAMPLE_W-1:0]      sample_y_i,
  input  logic [SIZE_W-1:0]        film_width_i,
  input  logic [SIZE_W-1:0]        film_height_i,
  output logic                     valid_o,
  output logic signed [MAP_W-1:0]  x_o,
  output logic signed [MAP_W-1:0]  y_o
);

  logic [SAMPLE_W-1:0] smp [2];
  logic [SIZE_W-1:0]   fsz [2];
  logic [MQ_W:0]       valid_q;

  logic [NUM_W-1:0] num_q [2][MQ_W+1];
  logic [NUM_W-1:0] num_d [2][MQ_W+1];
  logic [MAG_W-1:0] den_q [2][MQ_W+1];
  logic [MAG_W-1:0] den_d [2][MQ_W+1];
  logic [MAG_W-1:0] rem_q [2][MQ_W+1];
  logic [MAG_W-1:0] rem_d [2][MQ_W+1];
  logic [MQ_W-1:0]  quo_q [2][MQ_W+1];
  logic [MQ_W-1:0]  quo_d [2][MQ_W+1];
  logic             neg_q [2][MQ_W+1];
  logic             neg_d [2][MQ_W+1];

  assign smp[0] = sample_x_i;
  assign smp[1] = sample_y_i;
  assign fsz[0] = film_width_i;
  assign fsz[1] = film_height_i;

  always_comb begin
    logic [SIZE_W-1:0] sz;
    logic [MAG_W-1:0]  den;
    logic [MAG_W-1:0]  two;
    logic [MAG_W-1:0]  mag;
    logic              neg;
    logic [NUM_W-1:0]  num;
    logic [MAG_W:0]    t;
    logic              ge;
    for (int l = 0; l < 2; l++) begin
      sz  = (fsz[l] == '0) ? SIZE_W'(1) : fsz[l];
      den = MAG_W'(sz) << SAMPLE_FRAC_BITS;
      two = MAG_W'({smp[l], 1'b0});
      neg = two < den;
      mag = neg ? den - two : two - den;
      num = NUM_W'({mag, {XF{1'b0}}}) + NUM_W'(den >> 1);
      num_d[l][0] = num;
      den_d[l][0] = den;
      rem_d[l][0] = MAG_W'(num >> MQ_W);
      quo_d[l][0] = '0;
      neg_d[l][0] = neg;
      for (int k = 1; k <= MQ_W; k++) begin
        t  = {rem_q[l][k-1], num_q[l][k-1][MQ_W-k]};
        ge = t >= {1'b0, den_q[l][k-1]};
        rem_d[l][k] = ge ? MAG_W'(t - {1'b0, den_q[l][k-1]}) : t[MAG_W-1:0];
        quo_d[l][k] = {quo_q[l][k-1][MQ_W-2:0], ge};
        num_d[l][k] = num_q[l][k-1];
        den_d[l][k] = den_q[l][k-1];
        neg_d[l][k] = neg_q[l][k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[MQ_W-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= num_d;
      den_q <= den_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
      neg_q <= neg_d;
    end
  end

  assign valid_o = valid_q[MQ_W];
  assign x_o = neg_q[0][MQ_W] ? -$signed({1'b0, quo_q[0][MQ_W]})
                              : $signed({1'b0, quo_q[0][MQ_W]});
  assign y_o = neg_q[1][MQ_W] ? -$signed({1'b0, quo_q[1][MQ_W]})
                              : $signed({1'b0, quo_q[1][MQ_W]});

endmodule

`default_nettype wire

[rtl/ppr_dir.sv]
// Direction sum: scaled basis products, view offset, sign and a staged
// normalizing shift of all three magnitudes. Depends on ppr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppr_dir import ppr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [MAP_W-1:0] x_i,
  input  logic signed [MAP_W-1:0] y_i,
  input  logic [VIEW_REG_W-1:0]   view_i,
  input  logic [VEC_REG_W-1:0]    right_i,
  input  logic [VEC_REG_W-1:0]    up_i,
  input  logic                    flip_i,
  output logic                    valid_o,
  output norm_t                   norm_o
);

  localparam int NSTG = NSH + 1;

  logic signed [PROD_W-1:0] pr_q [3];
  logic signed [PROD_W-1:0] pu_q [3];
  logic signed [PROD_W-1:0] pr_d [3];
  logic signed [PROD_W-1:0] pu_d [3];
  logic [NORM_W-1:0]        m_q [NSTG+1][3];
  logic [NORM_W-1:0]        m_d [NSTG+1][3];
  logic [NORM_W-1:0]        b_q [1:NSTG];
  logic [NORM_W-1:0]        b_d [1:NSTG];
  logic [2:0]               n_q [NSTG+1];
  logic [2:0]               n_d [NSTG+1];
  logic [NSTG+1:0]          valid_q;

  always_comb begin
    logic signed [SUM_W-1:0] dv;
    logic signed [SUM_W-1:0] d;
    logic [SUM_W-1:0]        mag;
    logic [NORM_W-1:0]       big;
    logic                    sh_en;
    int                      sh;
    for (int i = 0; i < 3; i++) begin
      pr_d[i] = $signed(right_i[i*VEC_W +: VEC_W]) * x_i;
      pu_d[i] = $signed(up_i[i*VEC_W +: VEC_W]) * y_i;
      dv = $signed({{(SUM_W-VIEW_W-XF){view_i[i*VIEW_W+VIEW_W-1]}},
                    view_i[i*VIEW_W +: VIEW_W], {XF{1'b0}}});
      d  = dv + SUM_W'(pr_q[i]) - SUM_W'(pu_q[i]);
      mag = d[SUM_W-1] ? SUM_W'(-d) : SUM_W'(d);
      m_d[0][i] = NORM_W'(mag);
      n_d[0][i] = d[SUM_W-1] ^ flip_i;
    end

    big = m_q[0][0];
    for (int i = 1; i < 3; i++) begin
      if (m_q[0][i] > big) begin
        big = m_q[0][i];
      end
    end
    b_d[1] = big;
    m_d[1] = m_q[0];
    n_d[1] = n_q[0];

    for (int s = 0; s < NSH; s++) begin
      sh    = (NORM_W / 2) >> s;
      sh_en = (b_q[s+1] >> (NORM_W - sh)) == '0;
      b_d[s+2] = sh_en ? b_q[s+1] << sh : b_q[s+1];
      for (int i = 0; i < 3; i++) begin
        m_d[s+2][i] = sh_en ? m_q[s+1][i] << sh : m_q[s+1][i];
      end
      n_d[s+2] = n_q[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[NSTG:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr_q <= pr_d;
      pu_q <= pu_d;
      m_q  <= m_d;
      b_q  <= b_d;
      n_q  <= n_d;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      norm_o.mag[i] = m_q[NSTG][i][NORM_W-1 -: NM_W];
    end
    norm_o.neg  = n_q[NSTG];
    norm_o.zero = b_q[NSTG] == '0;
  end

  assign valid_o = valid_q[NSTG+1];

endmodule

`default_nettype wire

[rtl/ppr_len.sv]
// Vector length: squares, sum of squares and a pipelined integer square
// root, one result bit per stage. Depends on ppr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppr_len import ppr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  norm_t            norm_i,
  output logic             valid_o,
  output norm_t            norm_o,
  output logic [LEN_W-1:0] len_o
);

  localparam int LAST = SQ_STEPS + 1;

  logic [SQ_W-1:0]  sq_q [3];
  logic [SQ_W-1:0]  sq_d [3];
  logic [SS_W-1:0]  rad_q [1:LAST];
  logic [SS_W-1:0]  rad_d [1:LAST];
  logic [RES_W-1:0] res_q [1:LAST];
  logic [RES_W-1:0] res_d [1:LAST];
  norm_t            nt_q [LAST+1];
  norm_t            nt_d [LAST+1];
  logic [LAST:0]    valid_q;

  always_comb begin
    logic [RES_W-1:0] bitv;
    logic [RES_W-1:0] trial;
    for (int i = 0; i < 3; i++) begin
      sq_d[i] = norm_i.mag[i] * norm_i.mag[i];
    end
    nt_d[0] = norm_i;
    rad_d[1] = SS_W'(sq_q[0]) + SS_W'(sq_q[1]) + SS_W'(sq_q[2]);
    res_d[1] = '0;
    nt_d[1]  = nt_q[0];
    for (int k = 2; k <= LAST; k++) begin
      bitv  = RES_W'(1) << (SS_W - 2 - 2 * (k - 2));
      trial = res_q[k-1] + bitv;
      if ({1'b0, rad_q[k-1]} >= trial) begin
        rad_d[k] = SS_W'({1'b0, rad_q[k-1]} - trial);
        res_d[k] = (res_q[k-1] >> 1) + bitv;
      end else begin
        rad_d[k] = rad_q[k-1];
        res_d[k] = res_q[k-1] >> 1;
      end
      nt_d[k] = nt_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[LAST-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q  <= sq_d;
      rad_q <= rad_d;
      res_q <= res_d;
      nt_q  <= nt_d;
    end
  end

  assign valid_o = valid_q[LAST];
  assign norm_o  = nt_q[LAST];
  assign len_o   = res_q[LAST][LEN_W-1:0];

endmodule

`default_nettype wire

[rtl/ppr_quot.sv]
// Per-component quotient magnitude times one over length, rounded, with a
// pipelined restoring divider in three lanes. Depends on ppr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppr_quot import ppr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  norm_t                 norm_i,
  input  logic [LEN_W-1:0]      len_i,
  output logic                  valid_o,
  output logic [2:0][QQ_W-1:0]  quo_o,
  output logic [2:0]            neg_o,
  output logic                  zero_o
);

  logic [QN_W-1:0]  num_q [QQ_W+1][3];
  logic [QN_W-1:0]  num_d [QQ_W+1][3];
  logic [QR_W-1:0]  rem_q [QQ_W+1][3];
  logic [QR_W-1:0]  rem_d [QQ_W+1][3];
  logic [QQ_W-1:0]  quo_q [QQ_W+1][3];
  logic [QQ_W-1:0]  quo_d [QQ_W+1][3];
  logic [LEN_W-1:0] len_q [QQ_W+1];
  logic [LEN_W-1:0] len_d [QQ_W+1];
  logic [2:0]       neg_q [QQ_W+1];
  logic [2:0]       neg_d [QQ_W+1];
  logic             zero_q [QQ_W+1];
  logic             zero_d [QQ_W+1];
  logic [QQ_W:0]    valid_q;

  always_comb begin
    logic [QN_W-1:0] num;
    logic [QR_W:0]   t;
    logic            ge;
    for (int i = 0; i < 3; i++) begin
      num = QN_W'({norm_i.mag[i], {DIR_FRAC_BITS{1'b0}}}) + QN_W'(len_i >> 1);
      num_d[0][i] = num;
      rem_d[0][i] = QR_W'(num >> QQ_W);
      quo_d[0][i] = '0;
    end
    len_d[0]  = len_i;
    neg_d[0]  = norm_i.neg;
    zero_d[0] = norm_i.zero;
    for (int k = 1; k <= QQ_W; k++) begin
      for (int i = 0; i < 3; i++) begin
        t  = {rem_q[k-1][i], num_q[k-1][i][QQ_W-k]};
        ge = t >= {1'b0, len_q[k-1]};
        rem_d[k][i] = ge ? QR_W'(t - {1'b0, len_q[k-1]}) : t[QR_W-1:0];
        quo_d[k][i] = {quo_q[k-1][i][QQ_W-2:0], ge};
        num_d[k][i] = num_q[k-1][i];
      end
      len_d[k]  = len_q[k-1];
      neg_d[k]  = neg_q[k-1];
      zero_d[k] = zero_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[QQ_W-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= num_d;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      len_q  <= len_d;
      neg_q  <= neg_d;
      zero_q <= zero_d;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      quo_o[i] = quo_q[QQ_W][i];
    end
  end

  assign valid_o = valid_q[QQ_W];
  assign neg_o   = neg_q[QQ_W];
  assign zero_o  = zero_q[QQ_W];

endmodule

`default_nettype wire

[rtl/pinhole_primary_ray_generator.sv]
// Pinhole primary ray generator top level: configuration registers,
// global stall, output register. Depends on ppr_pkg, ppr_ifs and submodules.
// Throughput: one word per cycle; the whole pipeline holds while the output stalls.
// Reset: valid bits clear at once; configuration registers return to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module pinhole_primary_ray_generator import ppr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ppr_sample_if.sink            sample_i,
  ppr_ray_if.source             ray_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [SIZE_W-1:0]     film_width_q;
  logic [SIZE_W-1:0]     film_height_q;
  logic [VIEW_REG_W-1:0] view_q;
  logic [VEC_REG_W-1:0]  right_q;
  logic [VEC_REG_W-1:0]  up_q;
  logic [FOCUS_W-1:0]    focus_q;
  logic [POS_REG_W-1:0]  cam_q;

  logic                    en;
  logic                    map_valid;
  logic signed [MAP_W-1:0] map_x;
  logic signed [MAP_W-1:0] map_y;
  logic                    dir_valid;
  norm_t                   dir_norm;
  logic                    len_valid;
  norm_t                   len_norm;
  logic [LEN_W-1:0]        len;
  logic                    quo_valid;
  logic [2:0][QQ_W-1:0]    quo;
  logic [2:0]              quo_neg;
  logic                    quo_zero;

  logic                    out_valid_q;
  logic [2:0][DIR_W-1:0]   dir_q;
  logic [2:0][DIR_W-1:0]   dir_d;
  logic [2:0][POS_W-1:0]   org_q;
  logic                    degen_q;
  logic                    degen_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      film_width_q  <= FILM_WIDTH_RST;
      film_height_q <= FILM_HEIGHT_RST;
      view_q        <= '0;
      right_q       <= '0;
      up_q          <= '0;
      focus_q       <= FOCUS_ONE;
      cam_q         <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_FILM_WIDTH:      film_width_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_FILM_HEIGHT:     film_height_q <= cfg_data_i[SIZE_W-1:0];
        CFG_VIEW_DIRECTION:  view_q        <= cfg_data_i[VIEW_REG_W-1:0];
        CFG_RIGHT_SCALED:    right_q       <= cfg_data_i[VEC_REG_W-1:0];
        CFG_UP_SCALED:       up_q          <= cfg_data_i[VEC_REG_W-1:0];
        CFG_FOCUS_DISTANCE:  focus_q       <= cfg_data_i[FOCUS_W-1:0];
        CFG_CAMERA_POSITION: cam_q         <= cfg_data_i[POS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign en             = !out_valid_q || ray_o.ready;
  assign sample_i.ready = en;

  ppr_map u_map (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (sample_i.valid),
    .sample_x_i    (sample_i.sample_x),
    .sample_y_i    (sample_i.sample_y),
    .film_width_i  (film_width_q),
    .film_height_i (film_height_q),
    .valid_o       (map_valid),
    .x_o           (map_x),
    .y_o           (map_y)
  );

  ppr_dir u_dir (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (map_valid),
    .x_i     (map_x),
    .y_i     (map_y),
    .view_i  (view_q),
    .right_i (right_q),
    .up_i    (up_q),
    .flip_i  (focus_q < FOCUS_ONE),
    .valid_o (dir_valid),
    .norm_o  (dir_norm)
  );

  ppr_len u_len (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dir_valid),
    .norm_i  (dir_norm),
    .valid_o (len_valid),
    .norm_o  (len_norm),
    .len_o   (len)
  );

  ppr_quot u_quot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (len_valid),
    .norm_i  (len_norm),
    .len_i   (len),
    .valid_o (quo_valid),
    .quo_o   (quo),
    .neg_o   (quo_neg),
    .zero_o  (quo_zero)
  );

  always_comb begin
    logic [DIR_W-1:0] qc;
    degen_d = quo_zero || (focus_q == FOCUS_ONE);
    for (int i = 0; i < 3; i++) begin
      qc = (quo[i] > QQ_W'(DIR_ONE)) ? DIR_ONE : DIR_W'(quo[i]);
      dir_d[i] = degen_d ? '0 : (quo_neg[i] ? DIR_W'(-qc) : qc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= quo_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dir_q   <= dir_d;
      degen_q <= degen_d;
      for (int i = 0; i < 3; i++) begin
        org_q[i] <= cam_q[i*POS_W +: POS_W];
      end
    end
  end

  assign ray_o.valid      = out_valid_q;
  assign ray_o.origin_x   = $signed(org_q[0]);
  assign ray_o.origin_y   = $signed(org_q[1]);
  assign ray_o.origin_z   = $signed(org_q[2]);
  assign ray_o.dir_x      = $signed(dir_q[0]);
  assign ray_o.dir_y      = $signed(dir_q[1]);
  assign ray_o.dir_z      = $signed(dir_q[2]);
  assign ray_o.degenerate = degen_q;

endmodule

`default_nettype wire

[rtl/ppr_checker.sv]
// Port-level checker for the pinhole primary ray generator, with its bind.
// Depends on ppr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppr_checker import ppr_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic signed [DIR_W-1:0] dir_x_i,
  input logic signed [DIR_W-1:0] dir_y_i,
  input logic signed [DIR_W-1:0] dir_z_i,
  input logic                    degenerate_i
);

  logic signed [DIR_W-1:0] dmax;
  logic signed [DIR_W-1:0] dmin;

  assign dmax = $signed(DIR_ONE);
  assign dmin = -$signed(DIR_ONE);

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && degenerate_i |-> dir_x_i == '0 && dir_y_i == '0 && dir_z_i == '0)
    else $error("degenerate ray with nonzero direction");

  a_dir_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !degenerate_i |-> dir_x_i != '0 || dir_y_i != '0 || dir_z_i != '0)
    else $error("regular ray with zero direction");

  a_dir_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> dir_x_i <= dmax && dir_x_i >= dmin && dir_y_i <= dmax &&
                    dir_y_i >= dmin && dir_z_i <= dmax && dir_z_i >= dmin)
    else $error("direction component beyond unit");

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i || out_ready_i |-> in_ready_i)
    else $error("input held while output free");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(dir_x_i) && $stable(degenerate_i))
    else $error("stalled ray word changed");

endmodule

bind pinhole_primary_ray_generator ppr_checker u_ppr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (sample_i.ready),
  .out_valid_i  (ray_o.valid),
  .out_ready_i  (ray_o.ready),
  .dir_x_i      (ray_o.dir_x),
  .dir_y_i      (ray_o.dir_y),
  .dir_z_i      (ray_o.dir_z),
  .degenerate_i (ray_o.degenerate)
);

`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for pinhole_primary_ray_generator.
// Drives film samples and camera settings, predicts each camera ray in a scoreboard class.
// Depends on ppr_pkg, ppr_ifs and the block RTL.
`timescale 1ns / 1ps

module tb_top;
  import ppr_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 120;
  localparam int HOLD_CYCLES    = 400;

  typedef struct {
    logic signed [POS_W-1:0] origin_x;
    logic signed [POS_W-1:0] origin_y;
    logic signed [POS_W-1:0] origin_z;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    logic                    degenerate;
  } ray_t;

  class ray_scoreboard;
    logic [SIZE_W-1:0]     film_width;
    logic [SIZE_W-1:0]     film_height;
    logic [VIEW_REG_W-1:0] view_direction;
    logic [VEC_REG_W-1:0]  right_scaled;
    logic [VEC_REG_W-1:0]  up_scaled;
    logic [FOCUS_W-1:0]    focus_distance;
    logic [POS_REG_W-1:0]  camera_position;
    ray_t                  pending_rays[$];
    int                    errors;

    function new();
      film_width      = FILM_WIDTH_RST;
      film_height     = FILM_HEIGHT_RST;
      view_direction  = '0;
      right_scaled    = '0;
      up_scaled       = '0;
      focus_distance  = FOCUS_ONE;
      camera_position = '0;
      errors          = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_FILM_WIDTH:      film_width      = d[SIZE_W-1:0];
        CFG_FILM_HEIGHT:     film_height     = d[SIZE_W-1:0];
        CFG_VIEW_DIRECTION:  view_direction  = d[VIEW_REG_W-1:0];
        CFG_RIGHT_SCALED:    right_scaled    = d[VEC_REG_W-1:0];
        CFG_UP_SCALED:       up_scaled       = d[VEC_REG_W-1:0];
        CFG_FOCUS_DISTANCE:  focus_distance  = d[FOCUS_W-1:0];
        CFG_CAMERA_POSITION: camera_position = d[POS_REG_W-1:0];
        default: ;
      endcase
    endfunction

    function longint map_coord(logic [SAMPLE_W-1:0] s, logic [SIZE_W-1:0] size);
      longint unsigned den, two, mag, q;
      den = longint'((size == 0) ? 1 : size) << SAMPLE_FRAC_BITS;
      two = longint'(s) * 2;
      mag = (two < den) ? den - two : two - den;
      q = ((mag << XF) + den / 2) / den;
      return (two < den) ? -longint'(q) : longint'(q);
    endfunction

    function longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] sx, logic [SAMPLE_W-1:0] sy);
      longint x, y, d;
      longint unsigned mag[3], big, sum, len, q;
      bit neg[3];
      ray_t r;
      x = map_coord(sx, film_width);
      y = map_coord(sy, film_height);
      big = 0;
      for (int i = 0; i < 3; i++) begin
        d = longint'($signed(view_direction[i*VIEW_W +: VIEW_W])) * (longint'(1) << XF)
          + longint'($signed(right_scaled[i*VEC_W +: VEC_W])) * x
          - longint'($signed(up_scaled[i*VEC_W +: VEC_W])) * y;
        if (focus_distance < FOCUS_ONE) d = -d;
        neg[i] = d < 0;
        mag[i] = neg[i] ? -d : d;
        if (mag[i] > big) big = mag[i];
      end
      r.origin_x   = camera_position[0*POS_W +: POS_W];
      r.origin_y   = camera_position[1*POS_W +: POS_W];
      r.origin_z   = camera_position[2*POS_W +: POS_W];
      r.dir_x      = '0;
      r.dir_y      = '0;
      r.dir_z      = '0;
      r.degenerate = (focus_distance == FOCUS_ONE) || (big == 0);
      if (!r.degenerate) begin
        while (big >= (64'd1 << 30)) begin
          big >>= 1;
          for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        while (big < (64'd1 << 29)) begin
          big <<= 1;
          for (int i = 0; i < 3; i++) mag[i] <<= 1;
        end
        sum = 0;
        for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
        len = floor_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
          q = ((mag[i] << DIR_FRAC_BITS) + len / 2) / len;
          if (q > DIR_ONE) q = DIR_ONE;
          mag[i] = neg[i] ? -q : q;
        end
        r.dir_x = mag[0][DIR_W-1:0];
        r.dir_y = mag[1][DIR_W-1:0];
        r.dir_z = mag[2][DIR_W-1:0];
      end
      pending_rays.push_back(r);
    endfunction

    function void check_ray(ray_t got);
      ray_t exp;
      if (pending_rays.size() == 0) begin
        $error("ray word with no expected ray");
        errors++;
        return;
      end
      exp = pending_rays.pop_front();
      if (got.origin_x !== exp.origin_x) begin
        $error("origin_x expected %0d got %0d", exp.origin_x, got.origin_x); errors++;
      end
      if (got.origin_y !== exp.origin_y) begin
        $error("origin_y expected %0d got %0d", exp.origin_y, got.origin_y); errors++;
      end
      if (got.origin_z !== exp.origin_z) begin
        $error("origin_z expected %0d got %0d", exp.origin_z, got.origin_z); errors++;
      end
      if (got.dir_x !== exp.dir_x) begin
        $error("dir_x expected %0d got %0d", exp.dir_x, got.dir_x); errors++;
      end
      if (got.dir_y !== exp.dir_y) begin
        $error("dir_y expected %0d got %0d", exp.dir_y, got.dir_y); errors++;
      end
      if (got.dir_z !== exp.dir_z) begin
        $error("dir_z expected %0d got %0d", exp.dir_z, got.dir_z); errors++;
      end
      if (got.degenerate !== exp.degenerate) begin
        $error("degenerate expected %0d got %0d", exp.degenerate, got.degenerate); errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  cfg_reg_e cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ppr_sample_if sample_ch ();
  ppr_ray_if    ray_ch ();

  pinhole_primary_ray_generator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (sample_ch.sink),
    .ray_o      (ray_ch.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  ray_scoreboard rays = new();
  bit idle_en = 1'b1;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        ray_ch.ready <= 1'b0;
      end else begin
        ray_ch.ready <= !(idle_en && $urandom_range(99) < 27);
      end
    end
  end

  always @(posedge clk_i) begin
    ray_t got;
    if (rst_ni && ray_ch.valid && ray_ch.ready) begin
      got.origin_x   = ray_ch.origin_x;
      got.origin_y   = ray_ch.origin_y;
      got.origin_z   = ray_ch.origin_z;
      got.dir_x      = ray_ch.dir_x;
      got.dir_y      = ray_ch.dir_y;
      got.dir_z      = ray_ch.dir_z;
      got.degenerate = ray_ch.degenerate;
      rays.check_ray(got);
    end
  end

  always @(posedge clk_i) begin
    if ((sample_ch.valid && sample_ch.ready) || (ray_ch.valid && ray_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("pinhole_primary_ray_generator regression: fail");
      $finish;
    end
  end

  task automatic program_camera(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                                input logic [VIEW_REG_W-1:0] view,
                                input logic [VEC_REG_W-1:0] right,
                                input logic [VEC_REG_W-1:0] up,
                                input logic [FOCUS_W-1:0] focus,
                                input logic [POS_REG_W-1:0] pos);
    logic [CFG_DATA_W-1:0] vals[7];
    vals[0] = CFG_DATA_W'(w); vals[1] = CFG_DATA_W'(h); vals[2] = CFG_DATA_W'(view);
    vals[3] = CFG_DATA_W'(right); vals[4] = CFG_DATA_W'(up);
    vals[5] = CFG_DATA_W'(focus); vals[6] = CFG_DATA_W'(pos);
    for (int i = 0; i < 7; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= cfg_reg_e'(i);
      cfg_data_i <= vals[i];
      rays.set_reg(cfg_reg_e'(i), vals[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] sx, input logic [SAMPLE_W-1:0] sy);
    while (idle_en && $urandom_range(99) < 27) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_ch.valid    <= 1'b1;
    sample_ch.sample_x <= sx;
    sample_ch.sample_y <= sy;
    do @(posedge clk_i); while (!sample_ch.ready);
    rays.note_sample(sx, sy);
  endtask

  task automatic drain_rays();
    sample_ch.valid <= 1'b0;
    while (rays.pending_rays.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic send_edges();
    send_sample(16'h0000, 16'h0000);
    send_sample(16'hFFFF, 16'hFFFF);
    send_sample(16'h0000, 16'hFFFF);
    send_sample(16'd5120, 16'd3840);
    send_sample(16'h5555, 16'hAAAA);
  endtask

  function automatic logic [VEC_REG_W-1:0] rand_vec();
    return VEC_REG_W'({$urandom, $urandom});
  endfunction

  initial begin
    logic [SIZE_W-1:0] w, h;
    logic [FOCUS_W-1:0] focus;
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CFG_FILM_WIDTH;
    cfg_data_i         <= '0;
    sample_ch.valid    <= 1'b0;
    sample_ch.sample_x <= '0;
    sample_ch.sample_y <= '0;
    ray_ch.ready       <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: focus at one, every ray degenerate
    send_edges();
    drain_rays();

    program_camera(13'd640, 13'd480, {16'sd16384, 16'sd0, 16'sd0},
                   {18'sd0, 18'sd0, 18'sd8192}, {18'sd0, 18'sd6144, 18'sd0},
                   24'd32768, {20'sd1024, -20'sd2048, 20'sd524287});
    send_edges();
    drain_rays();

    // focus below one negates the direction
    program_camera(13'd0, 13'd4096, {16'sd16384, 16'sd0, 16'sd0},
                   {18'sd0, 18'sd0, 18'sd8192}, {18'sd0, 18'sd6144, 18'sd0},
                   24'd0, {-20'sd524288, 20'sd0, -20'sd1});
    send_edges();
    drain_rays();

    // zero-length sum
    program_camera(13'd1, 13'd0, '0, '0, '0, 24'hFFFFFF, {60{1'b1}});
    send_sample(16'd7, 16'd9);
    send_sample(16'hFFFF, 16'h0000);
    drain_rays();

    // extreme vector fields, oversize film
    program_camera(13'h1FFF, 13'd4096, {3{16'h8000}}, {3{18'h1FFFF}}, {3{18'h20000}},
                   24'd16385, 60'h5A5A5A5A5A5A5A5);
    send_edges();
    send_sample(16'h7FFF, 16'h8000);
    drain_rays();

    for (int phase = 0; phase < 7; phase++) begin
      w = ($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(1, 64));
      h = ($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(1, 64));
      case ($urandom_range(5))
        0:       focus = FOCUS_ONE;
        1:       focus = 24'($urandom_range(0, 16383));
        default: focus = 24'($urandom_range(16385, 24'hFFFFFF));
      endcase
      program_camera(w, h, VIEW_REG_W'({$urandom, $urandom}), rand_vec(), rand_vec(),
                     focus, POS_REG_W'({$urandom, $urandom}));
      idle_en = (phase != 2);
      if (phase == 4) hold_req = 1'b1;
      for (int n = 0; n < 90; n++) begin
        if (phase == 5 && n == 45) begin
          drain_rays();
        end
        if ($urandom_range(3) == 0)
          send_sample(16'($urandom), 16'($urandom));
        else
          send_sample(16'($urandom_range(0, 2 * 16 * w + 40)),
                      16'($urandom_range(0, 2 * 16 * h + 40)));
      end
      idle_en = 1'b1;
      drain_rays();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (rays.errors == 0 && rays.pending_rays.size() == 0)
      $display("pinhole_primary_ray_generator regression: pass");
    else
      $display("pinhole_primary_ray_generator regression: fail");
    $finish;
  end

endmodule

[files.f]
rtl/ppr_pkg.sv
rtl/ppr_ifs.sv
rtl/ppr_map.sv
rtl/ppr_dir.sv
rtl/ppr_len.sv
rtl/ppr_quot.sv
rtl/pinhole_primary_ray_generator.sv
rtl/ppr_checker.sv
verif/tb_top.sv
